// ===== hw/rtl/pra_pkg.sv =====
// Shared types, widths and constants of the PID regulator with integral anti-windup.
`default_nettype none

package pra_pkg;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CfgGainP    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGainI    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainD    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxInput = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxInteg = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMaxOut   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgPeriod   = 3'd6;

  // Field widths.
  localparam int unsigned GainW     = 16;
  localparam int unsigned LimW      = 15;
  localparam int unsigned MaxIntegW = 31;
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned DriveW    = 16;

  // Internal datapath widths.
  localparam int unsigned ErrW   = 17;  // target minus measurement
  localparam int unsigned DiffW  = 18;  // previous error minus error
  localparam int unsigned IntegW = 32;  // integral in error-milliseconds
  localparam int unsigned AddW   = 34;  // error times period
  localparam int unsigned DerivW = 28;  // derivative in error per second
  localparam int unsigned AccW   = 48;  // controller sum with 8 fraction bits
  localparam int unsigned WideW  = 35;  // integral update before clamping

  // Shared multiplier operands and product.
  localparam int unsigned MulAW = 18;
  localparam int unsigned MulBW = 33;
  localparam int unsigned ProdW = MulAW + MulBW;

  // Shared divider.
  localparam int unsigned DivW        = AccW;
  localparam int unsigned DivisorW    = PeriodW;
  localparam int unsigned DivStepsDef = 2;

  // Milliseconds per second, the scale of the integral and derivative terms.
  localparam logic [DivisorW-1:0] MilliScale = 16'd1000;

  // Reset values of the configuration registers.
  localparam logic [LimW-1:0]      MaxInputRst = 15'h7fff;
  localparam logic [MaxIntegW-1:0] MaxIntegRst = 31'h7fffffff;
  localparam logic [LimW-1:0]      MaxOutRst   = 15'h7fff;
  localparam logic [PeriodW-1:0]   PeriodRst   = 16'd1;

  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [LimW-1:0]         max_input;
    logic [MaxIntegW-1:0]    max_integral;
    logic [LimW-1:0]         max_output;
    logic [PeriodW-1:0]      period_ms;
  } cfg_t;

  typedef struct packed {
    logic                   start;
    logic signed [DivW-1:0] dividend;
    logic [DivisorW-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pra_cfg.sv =====
// Configuration register file of the PID regulator.
`default_nettype none

module pra_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pra_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pra_pkg::CfgDataW-1:0]  cfg_data_i,
  output pra_pkg::cfg_t                      cfg_o
);
  import pra_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register write decode; indexes past the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgGainP:    cfg_d.gain_p       = $signed(cfg_data_i[GainW-1:0]);
        CfgGainI:    cfg_d.gain_i       = $signed(cfg_data_i[GainW-1:0]);
        CfgGainD:    cfg_d.gain_d       = $signed(cfg_data_i[GainW-1:0]);
        CfgMaxInput: cfg_d.max_input    = cfg_data_i[LimW-1:0];
        CfgMaxInteg: cfg_d.max_integral = cfg_data_i[MaxIntegW-1:0];
        CfgMaxOut:   cfg_d.max_output   = cfg_data_i[LimW-1:0];
        CfgPeriod:   cfg_d.period_ms    = cfg_data_i[PeriodW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p       <= '0;
      cfg_q.gain_i       <= '0;
      cfg_q.gain_d       <= '0;
      cfg_q.max_input    <= MaxInputRst;
      cfg_q.max_integral <= MaxIntegRst;
      cfg_q.max_output   <= MaxOutRst;
      cfg_q.period_ms    <= PeriodRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pra_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none

module pra_mul (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [pra_pkg::MulAW-1:0]  a_i,
  input  wire logic signed [pra_pkg::MulBW-1:0]  b_i,
  output logic signed [pra_pkg::ProdW-1:0]       prod_o
);
  import pra_pkg::*;

  logic signed [ProdW-1:0] prod_q, prod_d;

  // Both operands are sign-extended to the product width.
  assign prod_d = a_i * b_i;

  // The product holds until the next operation is issued.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pra_div.sv =====
// Shared iterative signed divider, truncating toward zero, with a positive divisor.
`default_nettype none

module pra_div #(
  parameter int unsigned StepsPerCycle = pra_pkg::DivStepsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pra_pkg::div_req_t div_req_i,
  output pra_pkg::div_rsp_t      div_rsp_o
);
  import pra_pkg::*;

  localparam int unsigned Iters = (DivW + StepsPerCycle - 1) / StepsPerCycle;
  localparam int unsigned QuotW = Iters * StepsPerCycle;
  localparam int unsigned CntW  = (Iters > 1) ? $clog2(Iters) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(Iters - 1);

  logic                   busy_q, fin_q, done_q, neg_q;
  logic [CntW-1:0]        cnt_q;
  logic [QuotW-1:0]       quot_q, quot_n;
  logic [DivisorW-1:0]    rem_q, rem_n;
  logic [DivisorW-1:0]    dvs_q;
  logic signed [DivW-1:0] res_q;
  logic [DivW-1:0]        mag;
  logic [DivisorW:0]      trial;

  // Magnitude of the dividend; the sign is applied again at the end.
  assign mag = div_req_i.dividend[DivW-1] ? DivW'(-div_req_i.dividend)
                                          : DivW'(div_req_i.dividend);

  // Restoring division, StepsPerCycle quotient bits per cycle.
  always_comb begin
    rem_n  = rem_q;
    quot_n = quot_q;
    trial  = '0;
    for (int k = 0; k < StepsPerCycle; k++) begin
      trial  = {rem_n, quot_n[QuotW-1]};
      quot_n = {quot_n[QuotW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial     = trial - {1'b0, dvs_q};
        quot_n[0] = 1'b1;
      end
      rem_n = trial[DivisorW-1:0];
    end
  end

  // Control: load, iterate, fix the sign, then report done for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (div_req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (div_req_i.start) begin
      quot_q <= QuotW'(mag);
      rem_q  <= '0;
      dvs_q  <= div_req_i.divisor;
      neg_q  <= div_req_i.dividend[DivW-1];
    end else if (busy_q) begin
      quot_q <= quot_n;
      rem_q  <= rem_n;
    end
    if (fin_q) begin
      res_q <= neg_q ? -$signed(quot_q[DivW-1:0]) : $signed(quot_q[DivW-1:0]);
    end
  end

  assign div_rsp_o.done     = done_q;
  assign div_rsp_o.quotient = res_q;

  // A new division is never started while one is still running.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_i.start |-> !busy_q && !fin_q)
    else $error("divider started while busy");

  // The sign fix-up always leads to done in the next cycle.
  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> done_q)
    else $error("divider result not reported");

  // Done is only reported once the iterations are over.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still iterating");

endmodule

`default_nettype wire

// ===== hw/rtl/pid_regulator_antiwindup_top.sv =====
// Top level of the PID regulator with integral clamp and anti-windup.
`default_nettype none

// PID regulator: each request carries a target, a measurement and an integral
// clear flag, and yields one saturated drive value with an at-limit flag. The
// input channel stalls from acceptance until the result is offered. The
// shared divider runs twice per request (the derivative divided by the period,
// and the integral term divided by 1000), while a single shared multiplier
// forms the five products. A finished result waits in the output register and
// the next request is accepted meanwhile. Configuration is written through its
// own port, which is always ready; registers must only be written while the
// block is idle.
module pid_regulator_antiwindup_top #(
  parameter int unsigned DivStepsPerCycle = pra_pkg::DivStepsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration writes.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pra_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pra_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input requests.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [pra_pkg::SampleW-1:0] target_i,
  input  wire logic signed [pra_pkg::SampleW-1:0] measured_i,
  input  wire logic                          clear_integral_i,
  // Results.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [pra_pkg::DriveW-1:0]  drive_o,
  output logic                               at_limit_o
);
  import pra_pkg::*;

  // Sequencer states.
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StErr  = 4'd1;   // error times period
  localparam logic [3:0] StInt  = 4'd2;   // integral update, difference times 1000
  localparam logic [3:0] StDiv1 = 4'd3;   // derivative division, proportional product
  localparam logic [3:0] StProp = 4'd4;   // integral product
  localparam logic [3:0] StWd1  = 4'd5;   // wait for the derivative
  localparam logic [3:0] StDiv2 = 4'd6;   // integral division, derivative product
  localparam logic [3:0] StDer  = 4'd7;   // add the derivative term
  localparam logic [3:0] StWd2  = 4'd8;   // wait for the integral term
  localparam logic [3:0] StSat  = 4'd9;   // shift and saturate
  localparam logic [3:0] StOut  = 4'd10;  // result out, anti-windup take-back

  localparam logic signed [WideW-1:0] Int32Max = 35'sd2147483647;
  localparam logic signed [WideW-1:0] Int32Min = -35'sd2147483648;

  cfg_t cfg;

  logic [3:0]                state_q, state_d;
  logic signed [ErrW-1:0]    e_q, e_d;
  logic signed [ErrW-1:0]    prev_q, prev_d;
  logic signed [DiffW-1:0]   diff_q, diff_d;
  logic signed [IntegW-1:0]  integ_q, integ_d;
  logic signed [AddW-1:0]    add_q, add_d;
  logic signed [DerivW-1:0]  dval_q, dval_d;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic signed [DriveW-1:0]  ysat_q, ysat_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [DriveW-1:0]  drive_q, drive_d;
  logic                      at_limit_q, at_limit_d;

  logic [PeriodW-1:0]        period_eff;
  logic                      mul_en;
  logic signed [MulAW-1:0]   mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [ProdW-1:0]   prod;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  logic signed [ErrW-1:0]    tgt17, meas17, lim_in, tgt_clamped;
  logic signed [WideW-1:0]   integ_sum, integ_lim, take_back;
  logic signed [AccW-9:0]    shifted, lim_out;
  logic signed [ErrW-1:0]    ysat17, lim_out17;
  logic                      limit_hit;
  logic                      out_free;

  pra_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pra_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  pra_div #(
    .StepsPerCycle (DivStepsPerCycle)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .div_req_i (div_req),
    .div_rsp_o (div_rsp)
  );

  // A zero period counts as one millisecond.
  assign period_eff = (cfg.period_ms == '0) ? PeriodW'(1) : cfg.period_ms;

  // Target clamp and error, formed as the request is accepted.
  assign tgt17  = ErrW'(target_i);
  assign meas17 = ErrW'(measured_i);
  assign lim_in = $signed({2'b00, cfg.max_input});
  always_comb begin
    if (tgt17 > lim_in) begin
      tgt_clamped = lim_in;
    end else if (tgt17 < -lim_in) begin
      tgt_clamped = -lim_in;
    end else begin
      tgt_clamped = tgt17;
    end
  end

  // Integral plus this step's addition, clamped to the integral limit.
  assign integ_sum = WideW'(integ_q) + WideW'($signed(prod[AddW-1:0]));
  assign integ_lim = $signed({4'b0000, cfg.max_integral});

  // Anti-windup take-back of this step's addition.
  assign take_back = WideW'(integ_q) - WideW'(add_q);

  // Floor shift of the controller sum and the output limit.
  assign shifted   = acc_q[AccW-1:8];
  assign lim_out   = $signed({{(AccW-8-LimW){1'b0}}, cfg.max_output});
  assign ysat17    = ErrW'(ysat_q);
  assign lim_out17 = $signed({2'b00, cfg.max_output});
  assign limit_hit = (ysat17 >= lim_out17) || (ysat17 <= -lim_out17);

  // The output register can take a new result.
  assign out_free = !out_valid_q || !out_stall_i;

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    mul_en           = 1'b0;
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = DivW'(prod);
    div_req.divisor  = period_eff;
    unique case (state_q)
      StErr: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(e_q);
        mul_b  = $signed(MulBW'(period_eff));
      end
      StInt: begin
        mul_en = 1'b1;
        mul_a  = diff_q;
        mul_b  = $signed(MulBW'(MilliScale));
      end
      StDiv1: begin
        mul_en        = 1'b1;
        mul_a         = MulAW'(cfg.gain_p);
        mul_b         = MulBW'(e_q);
        div_req.start = 1'b1;
      end
      StProp: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(cfg.gain_i);
        mul_b  = MulBW'(integ_q);
      end
      StDiv2: begin
        mul_en          = 1'b1;
        mul_a           = MulAW'(cfg.gain_d);
        mul_b           = MulBW'(dval_q);
        div_req.start   = 1'b1;
        div_req.divisor = MilliScale;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Sequencer and datapath registers.
  always_comb begin
    state_d     = state_q;
    e_d         = e_q;
    prev_d      = prev_q;
    diff_d      = diff_q;
    integ_d     = integ_q;
    add_d       = add_q;
    dval_d      = dval_q;
    acc_d       = acc_q;
    ysat_d      = ysat_q;
    out_valid_d = out_valid_q && out_stall_i;
    drive_d     = drive_q;
    at_limit_d  = at_limit_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          e_d = ErrW'(tgt_clamped - meas17);
          if (clear_integral_i) begin
            integ_d = '0;
          end
          state_d = StErr;
        end
      end
      StErr: begin
        diff_d  = DiffW'(prev_q) - DiffW'(e_q);
        prev_d  = e_q;
        state_d = StInt;
      end
      StInt: begin
        add_d = prod[AddW-1:0];
        if (integ_sum > integ_lim) begin
          integ_d = IntegW'(integ_lim);
        end else if (integ_sum < -integ_lim) begin
          integ_d = IntegW'(-integ_lim);
        end else begin
          integ_d = IntegW'(integ_sum);
        end
        state_d = StDiv1;
      end
      StDiv1: begin
        state_d = StProp;
      end
      StProp: begin
        acc_d   = AccW'(prod);
        state_d = StWd1;
      end
      StWd1: begin
        if (div_rsp.done) begin
          dval_d  = div_rsp.quotient[DerivW-1:0];
          state_d = StDiv2;
        end
      end
      StDiv2: begin
        state_d = StDer;
      end
      StDer: begin
        acc_d   = acc_q + AccW'(prod);
        state_d = StWd2;
      end
      StWd2: begin
        if (div_rsp.done) begin
          acc_d   = acc_q + div_rsp.quotient;
          state_d = StSat;
        end
      end
      StSat: begin
        if (shifted > lim_out) begin
          ysat_d = DriveW'(lim_out);
        end else if (shifted < -lim_out) begin
          ysat_d = DriveW'(-lim_out);
        end else begin
          ysat_d = DriveW'(shifted);
        end
        state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          drive_d     = ysat_q;
          at_limit_d  = limit_hit;
          if (limit_hit) begin
            if (take_back > Int32Max) begin
              integ_d = IntegW'(Int32Max);
            end else if (take_back < Int32Min) begin
              integ_d = IntegW'(Int32Min);
            end else begin
              integ_d = IntegW'(take_back);
            end
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state and the controller's own state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      prev_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      integ_q     <= integ_d;
      prev_q      <= prev_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    e_q        <= e_d;
    diff_q     <= diff_d;
    add_q      <= add_d;
    dval_q     <= dval_d;
    acc_q      <= acc_d;
    ysat_q     <= ysat_d;
    drive_q    <= drive_d;
    at_limit_q <= at_limit_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign at_limit_o  = at_limit_q;

  // An accepted request keeps the input stalled while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a request was accepted");

  // A finished result is held back while the output register is still full.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && out_valid_q && out_stall_i) |=> state_q == StOut)
    else $error("result overwrote a pending output");

  // The saturated drive never reaches the most negative code.
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_o != 16'sh8000)
    else $error("drive outside the saturation range");

endmodule

`default_nettype wire

// ===== test/pid_regulator_antiwindup_top_test.sv =====
// Self-checking testbench of the PID regulator with integral clamp and anti-windup.
`timescale 1ns / 1ps

module pid_regulator_antiwindup_top_test;
  import pra_pkg::*;

  localparam int unsigned StallLimit   = 4000;  // cycles with no handshake at all
  localparam int unsigned HoldCycles   = 400;   // long receiver hold-off
  localparam int unsigned SettleCycles = 80;    // block latency plus margin
  localparam int unsigned RandomPhases = 12;
  localparam int unsigned PhaseItems   = 96;

  // Index past the last register; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  typedef struct {
    logic signed [SampleW-1:0] target;
    logic signed [SampleW-1:0] measured;
    logic                      clear_integral;
  } request_t;

  typedef struct {
    logic signed [DriveW-1:0] drive;
    logic                     at_limit;
  } drive_t;

  // Tracks register and loop state, predicts each drive and checks results in order.
  class drive_scoreboard;
    cfg_t                     regs;
    logic signed [IntegW-1:0] integral;
    logic signed [ErrW-1:0]   last_err;
    drive_t                   due_q[$];
    int unsigned              requests, results, saturated, clears, wraps, errors;

    function new();
      regs.gain_p       = '0;
      regs.gain_i       = '0;
      regs.gain_d       = '0;
      regs.max_input    = MaxInputRst;
      regs.max_integral = MaxIntegRst;
      regs.max_output   = MaxOutRst;
      regs.period_ms    = PeriodRst;
      integral          = '0;
      last_err          = '0;
      requests          = 0;
      results           = 0;
      saturated         = 0;
      clears            = 0;
      wraps             = 0;
      errors            = 0;
    endfunction

    function longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function void note_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgGainP:    regs.gain_p       = data[GainW-1:0];
        CfgGainI:    regs.gain_i       = data[GainW-1:0];
        CfgGainD:    regs.gain_d       = data[GainW-1:0];
        CfgMaxInput: regs.max_input    = data[LimW-1:0];
        CfgMaxInteg: regs.max_integral = data[MaxIntegW-1:0];
        CfgMaxOut:   regs.max_output   = data[LimW-1:0];
        CfgPeriod:   regs.period_ms    = data[PeriodW-1:0];
        default: ;
      endcase
    endfunction

    // Advances the loop state by one sample and queues the drive it should give.
    function void note_request(request_t req);
      longint tv, mv, per, e, add, d, s, y, ival, lim_o;
      bit     hit;
      drive_t want;
      lim_o = longint'(regs.max_output);
      tv    = clamp_sym(longint'(req.target), longint'(regs.max_input));
      mv    = longint'(req.measured);
      per   = (regs.period_ms == '0) ? 1 : longint'(regs.period_ms);
      e     = tv - mv;
      add   = e * per;
      ival  = req.clear_integral ? 0 : longint'(integral);
      ival  = clamp_sym(ival + add, longint'(regs.max_integral));
      d     = ((longint'(last_err) - e) * 1000) / per;
      last_err = e[ErrW-1:0];
      s = longint'($signed(regs.gain_p)) * e
        + (longint'($signed(regs.gain_i)) * ival) / 1000
        + longint'($signed(regs.gain_d)) * d;
      y   = clamp_sym(s >>> 8, lim_o);
      hit = (y >= lim_o) || (y <= -lim_o);
      // At the limit this step's contribution is removed again.
      if (hit) begin
        ival = ival - add;
        if (ival > 64'sd2147483647) begin
          ival = 64'sd2147483647;
          wraps++;
        end else if (ival < -64'sd2147483648) begin
          ival = -64'sd2147483648;
          wraps++;
        end
      end
      integral      = ival[IntegW-1:0];
      want.drive    = y[DriveW-1:0];
      want.at_limit = hit;
      due_q.push_back(want);
      requests++;
      if (hit) saturated++;
      if (req.clear_integral) clears++;
    endfunction

    function void check_result(logic signed [DriveW-1:0] drive, logic at_limit);
      drive_t want;
      if (due_q.size() == 0) begin
        $display("%0t: result with nothing pending: drive %0d at_limit %0b",
                 $time, drive, at_limit);
        errors++;
        return;
      end
      want = due_q.pop_front();
      results++;
      if (drive !== want.drive) begin
        $display("%0t: drive mismatch: expected %0d, got %0d", $time, want.drive, drive);
        errors++;
      end
      if (at_limit !== want.at_limit) begin
        $display("%0t: at_limit mismatch: expected %0b, got %0b",
                 $time, want.at_limit, at_limit);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni           = 1'b0;
  logic                        cfg_valid_i      = 1'b0;
  logic                        cfg_ready_o;
  logic [CfgIdxW-1:0]          cfg_index_i      = '0;
  logic [CfgDataW-1:0]         cfg_data_i       = '0;
  logic                        in_valid_i       = 1'b0;
  logic                        in_stall_o;
  logic signed [SampleW-1:0]   target_i         = '0;
  logic signed [SampleW-1:0]   measured_i       = '0;
  logic                        clear_integral_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i      = 1'b0;
  logic signed [DriveW-1:0]    drive_o;
  logic                        at_limit_o;

  drive_scoreboard sb;
  bit              steady      = 1'b0;  // no idling on either side
  int unsigned     holds_asked = 0;
  int unsigned     holds_done  = 0;
  int unsigned     settings    = 0;

  pid_regulator_antiwindup_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .target_i         (target_i),
    .measured_i       (measured_i),
    .clear_integral_i (clear_integral_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_o          (drive_o),
    .at_limit_o       (at_limit_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Writes one register; bits above the field width carry random junk.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val,
                           int unsigned w);
    logic [CfgDataW-1:0] mask, data;
    mask = (w >= CfgDataW) ? '1 : ((32'd1 << w) - 32'd1);
    data = ($urandom & ~mask) | (val & mask);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.note_config(idx, data);
    @(negedge clk_i);
  endtask

  task automatic configure(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                           logic [31:0] lim_in, logic [31:0] lim_int,
                           logic [31:0] lim_out, logic [31:0] per, bit poke_unused);
    write_reg(CfgGainP, gp, GainW);
    write_reg(CfgGainI, gi, GainW);
    write_reg(CfgGainD, gd, GainW);
    write_reg(CfgMaxInput, lim_in, LimW);
    write_reg(CfgMaxInteg, lim_int, MaxIntegW);
    write_reg(CfgMaxOut, lim_out, LimW);
    write_reg(CfgPeriod, per, PeriodW);
    if (poke_unused) write_reg(CfgUnused, $urandom, CfgDataW);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    settings++;
  endtask

  // Offers one request, after an optional gap, and holds it until accepted.
  task automatic send_item(request_t req);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 15) gap = $urandom_range(1, 70);
    while (gap != 0) begin
      in_valid_i <= 1'b0;
      gap--;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    target_i         <= req.target;
    measured_i       <= req.measured;
    clear_integral_i <= req.clear_integral;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req);
    @(negedge clk_i);
  endtask

  task automatic offer(int t, int m, bit clr);
    request_t req;
    req.target         = t[SampleW-1:0];
    req.measured       = m[SampleW-1:0];
    req.clear_integral = clr;
    send_item(req);
  endtask

  // Lets every pending result come out, then lets the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 32'h8000;
      1:       return 32'h7fff;
      2:       return 32'h0;
      3, 4:    return $urandom;
      default: return 32'($urandom_range(0, 1200)) - 32'd600;
    endcase
  endfunction

  function automatic logic [31:0] pick_clamp();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'h7fff;
      2, 3:    return $urandom;
      default: return $urandom_range(1, 3000);
    endcase
  endfunction

  function automatic logic [31:0] pick_integ_clamp();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'h7fffffff;
      2:       return $urandom;
      default: return $urandom_range(0, 500000);
    endcase
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'h1;
      2:       return 32'hffff;
      3:       return $urandom;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // Often a loop that tracks its target, with noise, rails and zero error mixed in.
  function automatic request_t random_request();
    request_t            req;
    logic [SampleW-1:0]  rails [4];
    int unsigned         mode;
    rails = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    mode  = $urandom_range(0, 99);
    if (mode < 45) begin
      req.target   = 16'($urandom_range(0, 4000)) - 16'd2000;
      req.measured = req.target + 16'($urandom_range(0, 600)) - 16'd300;
    end else if (mode < 75) begin
      req.target   = $urandom;
      req.measured = $urandom;
    end else if (mode < 90) begin
      req.target   = rails[$urandom_range(0, 3)];
      req.measured = rails[$urandom_range(0, 3)];
    end else begin
      req.target   = $urandom;
      req.measured = req.target;
    end
    req.clear_integral = ($urandom_range(0, 11) == 0);
    return req;
  endfunction

  // Result side: checks every accepted result and drives the stall.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_result(drive_o, at_limit_o);
      @(negedge clk_i);
      if (holds_done < holds_asked) begin
        holds_done++;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (steady) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 8);
      end
    end
  end

  // Ends the run when no handshake of any kind happens for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no progress for %0d cycles, %0d results pending",
             $time, StallLimit, sb.pending());
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase, n;
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero period, clamped target, integral clear and a write past the last register.
    configure(32'd256, 32'd64, 32'hfff8, 32'd1000, 32'd50000, 32'd2000, 32'd0, 1'b1);
    offer(32767, -32768, 1'b0);
    offer(-32768, 32767, 1'b0);
    offer(0, 0, 1'b1);
    offer(300, 100, 1'b0);
    offer(300, 250, 1'b0);
    offer(-1, 0, 1'b0);
    offer(1000, 1000, 1'b1);
    offer(-1000, -1500, 0);
    drain();

    // Saturated output with a zero integral limit: the take-back leaves 32-bit range.
    configure(32'h7fff, 32'h7fff, 32'h0, 32'h7fff, 32'h0, 32'd100, 32'hffff, 1'b0);
    offer(-32768, 32767, 1'b0);
    offer(32767, -32768, 1'b0);
    offer(0, 0, 1'b0);
    offer(5, 0, 1'b1);
    offer(-32768, 32767, 1'b0);
    drain();

    // Zero output limit, zero target limit and most negative gains.
    configure(32'h8000, 32'h8000, 32'h8000, 32'h0, 32'h7fffffff, 32'h0, 32'd1, 1'b0);
    offer(100, -100, 1'b0);
    offer(-32768, -32768, 1'b1);
    offer(32767, 32767, 1'b0);
    offer(0, 123, 1'b0);
    drain();

    // Largest positive gains with every limit wide open.
    configure(32'h7fff, 32'h7fff, 32'h7fff, 32'h7fff, 32'h7fffffff, 32'h7fff, 32'hffff,
              1'b0);
    offer(1, 0, 1'b0);
    offer(0, 1, 1'b0);
    offer(0, 0, 1'b0);
    offer(-32768, -32768, 1'b0);
    drain();

    // Random settings, each followed by a run of random samples.
    for (phase = 0; phase < RandomPhases; phase++) begin
      configure(pick_gain(), pick_gain(), pick_gain(), pick_clamp(), pick_integ_clamp(),
                pick_clamp(), pick_period(), ($urandom_range(0, 2) == 0));
      steady = (phase == 5);
      if (phase == 2) holds_asked++;
      for (n = 0; n < PhaseItems; n++) send_item(random_request());
      drain();
    end
    steady = 1'b0;

    $display("covered %0d requests under %0d register settings, %0d results checked",
             sb.requests, settings, sb.results);
    $display("%0d results at the output limit, %0d integral clears, %0d take-back saturations",
             sb.saturated, sb.clears, sb.wraps);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
